// ===== rtl/core/servo_bus_status_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// Servo bus status deframer assertion macros
// Small wrappers around concurrent assertions used by the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_STATUS_DEFRAMER_ASSERT_SVH
`define SERVO_BUS_STATUS_DEFRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVBD_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVBD_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/svbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer package
// Opcodes, status codes, phase codes and the shared state and result types.
// ----------------------------------------------------------------------------
package svbd_pkg;

  // Input opcodes.
  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Final status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_BADLEN   = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_DEVERR   = 3'd4;

  // Result kinds.
  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Receiver phases.
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  // Header layout: two start bytes, identifier, length.
  localparam logic [7:0] HDR_POS_ID  = 8'd2;
  localparam logic [7:0] HDR_POS_LEN = 8'd3;
  localparam logic [7:0] HDR_BYTES   = 8'd4;
  localparam logic [7:0] MIN_LENGTH  = 8'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]  phase;
    logic [7:0]  byte_pos;
    logic [7:0]  frame_len;
    logic [7:0]  run_sum;
    logic [7:0]  held_id;
    logic [7:0]  held_err;
    logic [15:0] idle_ticks;
  } svbd_state_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] param_index;
    logic [7:0] param_value;
    logic [7:0] device_id;
    logic [7:0] device_error;
    logic [2:0] status;
  } svbd_result_t;

endpackage

// ===== rtl/core/svbd_step.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer step logic
// Combinational next-state and result logic for one transaction.
// ----------------------------------------------------------------------------
module svbd_step (
  input  svbd_pkg::svbd_state_t  state_i,
  input  logic [1:0]             op_i,
  input  logic [7:0]             rx_byte_i,
  input  logic [15:0]            timeout_i,
  output svbd_pkg::svbd_state_t  state_o,
  output svbd_pkg::svbd_result_t result_o
);

  logic [15:0] tick_inc;
  logic [7:0]  pos_inc;
  logic [7:0]  len_new;
  logic        body_last;

  assign tick_inc  = (state_i.idle_ticks == '1) ? state_i.idle_ticks
                                                : state_i.idle_ticks + 16'd1;
  assign pos_inc   = state_i.byte_pos + 8'd1;
  assign len_new   = (state_i.byte_pos == svbd_pkg::HDR_POS_LEN) ? rx_byte_i
                                                                : state_i.frame_len;
  assign body_last = ({1'b0, state_i.byte_pos} + 9'd1) >= {1'b0, state_i.frame_len};

  always_comb begin
    state_o  = state_i;
    result_o = '0;

    unique case (op_i)
      svbd_pkg::OP_ARM: begin
        state_o       = '0;
        state_o.phase = svbd_pkg::PH_HEADER;
      end
      svbd_pkg::OP_TICK: begin
        if (state_i.phase != svbd_pkg::PH_IDLE) begin
          state_o.idle_ticks = tick_inc;
          if (tick_inc >= timeout_i) begin
            state_o.phase   = svbd_pkg::PH_IDLE;
            result_o.valid  = 1'b1;
            result_o.kind   = svbd_pkg::KIND_STATUS;
            result_o.status = svbd_pkg::ST_TIMEOUT;
          end
        end
      end
      svbd_pkg::OP_BYTE: begin
        if (state_i.phase == svbd_pkg::PH_HEADER) begin
          state_o.idle_ticks = '0;
          if (state_i.byte_pos == svbd_pkg::HDR_POS_ID) begin
            state_o.held_id = rx_byte_i;
            state_o.run_sum = state_i.run_sum + rx_byte_i;
          end else if (state_i.byte_pos == svbd_pkg::HDR_POS_LEN) begin
            state_o.frame_len = rx_byte_i;
            state_o.run_sum   = state_i.run_sum + rx_byte_i;
          end
          state_o.byte_pos = pos_inc;
          if (pos_inc >= svbd_pkg::HDR_BYTES) begin
            state_o.byte_pos = '0;
            if (len_new < svbd_pkg::MIN_LENGTH) begin
              state_o.phase   = svbd_pkg::PH_IDLE;
              result_o.valid  = 1'b1;
              result_o.kind   = svbd_pkg::KIND_STATUS;
              result_o.status = svbd_pkg::ST_BADLEN;
            end else begin
              state_o.phase = svbd_pkg::PH_BODY;
            end
          end
        end else if (state_i.phase == svbd_pkg::PH_BODY) begin
          state_o.idle_ticks = '0;
          if (body_last) begin
            // Checksum byte: a mismatch wins over a device error.
            state_o.phase  = svbd_pkg::PH_IDLE;
            result_o.valid = 1'b1;
            result_o.kind  = svbd_pkg::KIND_STATUS;
            if (rx_byte_i != ~state_i.run_sum) begin
              result_o.status = svbd_pkg::ST_CHECKSUM;
            end else if (state_i.held_err != 8'd0) begin
              result_o.status = svbd_pkg::ST_DEVERR;
            end else begin
              result_o.status = svbd_pkg::ST_OK;
            end
          end else begin
            state_o.run_sum = state_i.run_sum + rx_byte_i;
            if (state_i.byte_pos == 8'd0) begin
              state_o.held_err = rx_byte_i;
              state_o.byte_pos = 8'd1;
            end else begin
              result_o.valid       = 1'b1;
              result_o.kind        = svbd_pkg::KIND_PARAM;
              result_o.param_index = state_i.byte_pos - 8'd1;
              result_o.param_value = rx_byte_i;
              state_o.byte_pos     = pos_inc;
            end
          end
        end
      end
      default: begin
        // Unused opcode: no state change, no result.
      end
    endcase

    // Identifier and error fields always reflect the values held so far.
    result_o.device_id    = state_o.held_id;
    result_o.device_error = state_o.held_err;
  end

endmodule

// ===== rtl/core/servo_bus_status_deframer.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer
// Receives servo bus status packets byte by byte and reports parameters and
// a final packet status.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one transaction per command. tuser holds
// the opcode (arm, received byte, timer tick) and tdata the received byte.
// After an arm, the block takes two start bytes, the identifier and the
// length, then the error byte, the parameters and the checksum. Each
// parameter byte produces an output transaction with kind zero, and the
// packet ends with one status transaction (ok, timeout, bad length, checksum
// mismatch or device error). Ticks count time since the last byte against
// the timeout register, which is written through cfg_we_i and cfg_wdata_i.
// An accepted transaction is loaded into the input register, and the step logic
// then loads its result into the output register once that register is free.
// Throughput is one transaction per cycle while the receiver does not stall,
// as the packet state is updated by combinational step logic. When the
// receiver stalls, the result stays in the output register, the input
// register still accepts one more transaction, and then s_axis_tready drops
// until space frees up. Reset empties both registers, puts the receiver in
// idle and sets the timeout to 1000 ticks.
// ----------------------------------------------------------------------------
`include "servo_bus_status_deframer_assert.svh"

module servo_bus_status_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // timeout_ticks

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] param_index, [15:8] param_value,
                                      // [23:16] device_id, [31:24] device_error,
                                      // [34:32] status, [39:35] zero
  output logic [0:0]  m_axis_tuser    // [0] kind
);

  // Timeout limit register.
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= svbd_pkg::TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Input register. It may take a new transaction while the output register
  // holds a result, so the two sides are decoupled.
  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_free;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // Packet state and step logic.
  svbd_pkg::svbd_state_t  state_q;
  svbd_pkg::svbd_state_t  state_d;
  svbd_pkg::svbd_result_t result;

  svbd_step u_step (
    .state_i  (state_q),
    .op_i     (in_op_q),
    .rx_byte_i(in_byte_q),
    .timeout_i(timeout_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // The all-zero state is the idle phase with every counter cleared.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Output register: reloaded whenever it is free, so a transaction that
  // produces no result simply leaves it empty.
  logic out_valid_q;
  svbd_pkg::svbd_result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {5'd0, out_q.status, out_q.device_error, out_q.device_id,
                          out_q.param_value, out_q.param_index};

  // A status result always returns the receiver to idle.
  `SVBD_ASSERT_NEXT(a_status_goes_idle, clk_i, rst_ni,
    advance && result.valid && (result.kind == svbd_pkg::KIND_STATUS),
    state_q.phase == svbd_pkg::PH_IDLE, "status result did not end the packet")

  // A pending parameter result means the packet body is still in progress.
  `SVBD_ASSERT_SAME(a_param_in_body, clk_i, rst_ni,
    out_valid_q && (out_q.kind == svbd_pkg::KIND_PARAM),
    state_q.phase == svbd_pkg::PH_BODY, "parameter result outside packet body")

  // The input side only stalls while a transaction is waiting in the input register.
  `SVBD_ASSERT_SAME(a_stall_only_when_full, clk_i, rst_ni,
    !s_axis_tready, in_valid_q && m_axis_tvalid && !m_axis_tready,
    "input stalled without a pending transaction")

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Servo bus status deframer testbench
// Sends arm, byte and tick transactions into the deframer. A cycle-free model
// of the receiver, kept inside the bench, predicts every parameter and status
// transaction. A checker compares each output transaction with the oldest
// prediction field by field. Both stream sides idle at random, and the
// timeout register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;

  // Opcode 3 has no meaning to the block. It must be ignored.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 4;     // two register stages plus margin
  localparam int QUIET_LIMIT  = 1000;  // cycles with no transaction at all
  localparam int RANDOM_ITEMS = 300;
  localparam int TICK_RUN     = 50;
  localparam int HOLD_CYCLES  = 80;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_index;
    logic [7:0] param_value;
    logic [7:0] device_id;
    logic [7:0] device_error;
    logic [2:0] status;
  } bus_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;                // [7:0] rx_byte
  logic [1:0]  s_axis_tuser = svbd_pkg::OP_TICK; // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [7:0] param_index, [15:8] param_value,
                                       // [23:16] device_id, [31:24] device_error,
                                       // [34:32] status
  logic [0:0]  m_axis_tuser;           // [0] kind

  always #6 clk_i = ~clk_i;

  servo_bus_status_deframer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // --------------------------------------------------------------------------
  // Receiver model. The variables start at their reset values, and the
  // timeout limit follows every register write made by the bench.
  // --------------------------------------------------------------------------
  logic [1:0]  rx_phase = svbd_pkg::PH_IDLE;
  logic [7:0]  rx_pos = '0;
  logic [7:0]  rx_len = '0;
  logic [7:0]  rx_sum = '0;
  logic [7:0]  rx_id = '0;
  logic [7:0]  rx_err = '0;
  logic [15:0] rx_ticks = '0;
  logic [15:0] timeout_limit = svbd_pkg::TIMEOUT_RESET;

  bus_report_t awaited_reports[$];

  int items_sent = 0;
  int reports_checked = 0;
  int error_count = 0;
  int status_tally[8];

  // Idling control for both sides. The eager flags give stretches without
  // gaps. The long hold is counted down by the sink process itself.
  bit src_eager = 1'b0;
  bit sink_eager = 1'b0;
  int sink_gap_left = 0;
  int sink_hold_left = 0;
  int quiet_cycles = 0;

  task automatic queue_report(input logic kind, input logic [7:0] idx,
                              input logic [7:0] val, input logic [2:0] status);
    bus_report_t r;
    r.kind         = kind;
    r.param_index  = idx;
    r.param_value  = val;
    r.device_id    = rx_id;
    r.device_error = rx_err;
    r.status       = status;
    awaited_reports.push_back(r);
  endtask

  task automatic close_packet(input logic [2:0] status);
    queue_report(svbd_pkg::KIND_STATUS, 8'd0, 8'd0, status);
    rx_phase = svbd_pkg::PH_IDLE;
  endtask

  // Advances the model by one accepted transaction and queues any result.
  task automatic track_receiver(input logic [1:0] op, input logic [7:0] b);
    logic [7:0] want_sum;
    if (op == svbd_pkg::OP_ARM) begin
      rx_phase = svbd_pkg::PH_HEADER;
      rx_pos   = '0;
      rx_len   = '0;
      rx_sum   = '0;
      rx_id    = '0;
      rx_err   = '0;
      rx_ticks = '0;
      return;
    end
    if (op == svbd_pkg::OP_TICK) begin
      if (rx_phase == svbd_pkg::PH_IDLE) return;
      if (rx_ticks != 16'hFFFF) rx_ticks = rx_ticks + 16'd1;
      if (rx_ticks >= timeout_limit) close_packet(svbd_pkg::ST_TIMEOUT);
      return;
    end
    if (op != svbd_pkg::OP_BYTE || rx_phase == svbd_pkg::PH_IDLE) return;

    rx_ticks = '0;
    if (rx_phase == svbd_pkg::PH_HEADER) begin
      if (rx_pos == svbd_pkg::HDR_POS_ID) begin
        rx_id  = b;
        rx_sum = rx_sum + b;
      end else if (rx_pos == svbd_pkg::HDR_POS_LEN) begin
        rx_len = b;
        rx_sum = rx_sum + b;
      end
      rx_pos = rx_pos + 8'd1;
      if (rx_pos >= svbd_pkg::HDR_BYTES) begin
        rx_pos = '0;
        if (rx_len < svbd_pkg::MIN_LENGTH) close_packet(svbd_pkg::ST_BADLEN);
        else rx_phase = svbd_pkg::PH_BODY;
      end
      return;
    end

    // Body. The last byte is the checksum, and a bad checksum takes
    // precedence over a device error.
    if ({1'b0, rx_pos} + 9'd1 >= {1'b0, rx_len}) begin
      want_sum = ~rx_sum;
      if (b != want_sum) close_packet(svbd_pkg::ST_CHECKSUM);
      else if (rx_err != 8'd0) close_packet(svbd_pkg::ST_DEVERR);
      else close_packet(svbd_pkg::ST_OK);
      return;
    end
    rx_sum = rx_sum + b;
    if (rx_pos == 8'd0) begin
      rx_err = b;
      rx_pos = 8'd1;
      return;
    end
    queue_report(svbd_pkg::KIND_PARAM, rx_pos - 8'd1, b, svbd_pkg::ST_OK);
    rx_pos = rx_pos + 8'd1;
  endtask

  // --------------------------------------------------------------------------
  // Mismatch reporting. Every mismatch prints one line and is counted.
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("MISMATCH at %0t: %s, got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Output side. The checker samples at the rising edge, and the sink
  // process drives tready at the falling edge.
  // --------------------------------------------------------------------------
  bus_report_t seen_report;
  bus_report_t due_report;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_report.kind         = m_axis_tuser[0];
      seen_report.param_index  = m_axis_tdata[7:0];
      seen_report.param_value  = m_axis_tdata[15:8];
      seen_report.device_id    = m_axis_tdata[23:16];
      seen_report.device_error = m_axis_tdata[31:24];
      seen_report.status       = m_axis_tdata[34:32];
      if (awaited_reports.size() == 0) begin
        flag_mismatch("result transaction with nothing expected", seen_report[31:0], 0);
      end else begin
        due_report = awaited_reports.pop_front();
        if (seen_report.kind != due_report.kind)
          flag_mismatch("kind", seen_report.kind, due_report.kind);
        if (seen_report.param_index != due_report.param_index)
          flag_mismatch("param_index", seen_report.param_index, due_report.param_index);
        if (seen_report.param_value != due_report.param_value)
          flag_mismatch("param_value", seen_report.param_value, due_report.param_value);
        if (seen_report.device_id != due_report.device_id)
          flag_mismatch("device_id", seen_report.device_id, due_report.device_id);
        if (seen_report.device_error != due_report.device_error)
          flag_mismatch("device_error", seen_report.device_error, due_report.device_error);
        if (seen_report.status != due_report.status)
          flag_mismatch("status", seen_report.status, due_report.status);
        if (due_report.kind == svbd_pkg::KIND_STATUS) status_tally[due_report.status]++;
      end
      reports_checked++;
      sink_gap_left = sink_eager ? 0 : $urandom_range(0, 8);
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (sink_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_left--;
      end else if (sink_gap_left > 0) begin
        m_axis_tready <= 1'b0;
        sink_gap_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // The watchdog ends the run if no transaction moves on either side for
  // too long, which also covers results that never arrive.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one transaction after a random gap, waits until it is accepted,
  // and then feeds it to the model. tvalid stays high until the next call or
  // until settle lowers it, so back-to-back transactions need no extra edge.
  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = src_eager ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    track_receiver(op, b);
    items_sent++;
  endtask

  // Stops offering, waits for every expected result, and then lets the
  // latency pass so that a transaction with no result is also finished.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_timeout(input logic [15:0] ticks);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    timeout_limit = ticks;
  endtask

  // Sends one status packet, starting with an arm. In the scrambled form the
  // start bytes and the parameters are random and short tick bursts fall
  // between bytes. Otherwise parameters alternate between all zeros and all
  // ones. A packet can be cut before byte cut_at, either by a flood of ticks
  // up to the limit or silently, in which case the next arm restarts it.
  task automatic send_packet(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] err, input bit bad_sum,
                             input bit scrambled, input int cut_at,
                             input bit cut_by_ticks);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] pb;
    sum = id + len + err;
    repeat (2) frame_bytes.push_back(scrambled ? 8'($urandom_range(0, 255)) : 8'hFF);
    frame_bytes.push_back(id);
    frame_bytes.push_back(len);
    if (len >= svbd_pkg::MIN_LENGTH) begin
      frame_bytes.push_back(err);
      for (int i = 0; i < int'(len) - 2; i++) begin
        pb  = scrambled ? 8'($urandom_range(0, 255)) : ((i % 2) ? 8'hFF : 8'h00);
        sum = sum + pb;
        frame_bytes.push_back(pb);
      end
      frame_bytes.push_back(~sum ^ (bad_sum ? 8'($urandom_range(1, 255)) : 8'h00));
    end
    send_item(svbd_pkg::OP_ARM, 8'($urandom_range(0, 255)));
    foreach (frame_bytes[i]) begin
      if (i == cut_at) begin
        if (cut_by_ticks)
          repeat (int'(timeout_limit)) send_item(svbd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        return;
      end
      if (scrambled && $urandom_range(0, 7) == 0)
        repeat ($urandom_range(1, 3)) send_item(svbd_pkg::OP_TICK, 8'($urandom_range(0, 255)));
      send_item(svbd_pkg::OP_BYTE, frame_bytes[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Bytes, ticks and the unused opcode while idle, then the unused opcode in
  // the middle of a header. None of these may produce a result.
  task automatic test_ignored_items();
    send_item(svbd_pkg::OP_BYTE, 8'hA5);
    send_item(svbd_pkg::OP_TICK, 8'h5A);
    send_item(OP_UNUSED, 8'hFF);
    send_item(svbd_pkg::OP_ARM, 8'h00);
    send_item(svbd_pkg::OP_BYTE, 8'hFF);
    send_item(svbd_pkg::OP_BYTE, 8'hFF);
    send_item(OP_UNUSED, 8'h00);
    send_item(svbd_pkg::OP_BYTE, 8'h01);   // identifier
    send_item(svbd_pkg::OP_BYTE, 8'h02);   // length
    send_item(svbd_pkg::OP_BYTE, 8'h00);   // error byte
    send_item(svbd_pkg::OP_BYTE, 8'hFC);   // checksum of 01 + 02 + 00
    send_item(svbd_pkg::OP_BYTE, 8'h33);   // idle again, so this is ignored
    settle();
  endtask

  // The timeout register comes out of reset at 1000 ticks, so runs of ticks
  // far below that limit never end a packet, and a byte restarts the count.
  task automatic test_reset_timeout();
    src_eager = 1'b1;
    send_item(svbd_pkg::OP_ARM, 8'h00);
    send_item(svbd_pkg::OP_BYTE, 8'hFF);
    repeat (TICK_RUN) send_item(svbd_pkg::OP_TICK, 8'h00);
    send_item(svbd_pkg::OP_BYTE, 8'hFF);
    repeat (TICK_RUN) send_item(svbd_pkg::OP_TICK, 8'hFF);
    src_eager = 1'b0;
    settle();
  endtask

  // Length below two, checksum errors, device errors, the precedence of a
  // bad checksum over a device error, and an arm in the middle of a packet.
  task automatic test_length_and_checksum();
    send_packet(8'hFF, 8'd0, 8'h00, 1'b0, 1'b0, -1, 1'b0);
    send_packet(8'h00, 8'd1, 8'h00, 1'b0, 1'b0, -1, 1'b0);
    send_packet(8'hFF, 8'd2, 8'h00, 1'b0, 1'b0, -1, 1'b0);
    send_packet(8'h42, 8'd2, 8'h00, 1'b1, 1'b0, -1, 1'b0);
    send_packet(8'h07, 8'd4, 8'h80, 1'b0, 1'b0, -1, 1'b0);
    send_packet(8'h07, 8'd3, 8'hFF, 1'b1, 1'b0, -1, 1'b0);
    send_packet(8'h11, 8'd6, 8'h00, 1'b0, 1'b0, 6, 1'b0);
    send_packet(8'hFE, 8'd6, 8'h00, 1'b0, 1'b0, -1, 1'b0);
    settle();
  endtask

  // Timeout limit at zero, one and the maximum. A zero limit ends a packet
  // on its first tick. The maximum limit lets long runs of ticks pass.
  task automatic test_timeout_limits();
    write_timeout(16'd0);
    send_item(svbd_pkg::OP_ARM, 8'hFF);
    send_item(svbd_pkg::OP_TICK, 8'h00);
    send_item(svbd_pkg::OP_TICK, 8'hFF);
    write_timeout(16'd1);
    send_item(svbd_pkg::OP_ARM, 8'h00);
    send_item(svbd_pkg::OP_BYTE, 8'hFF);
    send_item(svbd_pkg::OP_BYTE, 8'hFF);
    send_item(svbd_pkg::OP_BYTE, 8'h3C);
    send_item(svbd_pkg::OP_TICK, 8'h00);
    write_timeout(16'hFFFF);
    src_eager = 1'b1;
    send_packet(8'h9A, 8'd5, 8'h21, 1'b0, 1'b0, 5, 1'b0);
    repeat (TICK_RUN) send_item(svbd_pkg::OP_TICK, 8'h00);
    send_item(svbd_pkg::OP_BYTE, 8'hC3);
    repeat (TICK_RUN) send_item(svbd_pkg::OP_TICK, 8'h00);
    src_eager = 1'b0;
    settle();
    write_timeout(16'd1000);
  endtask

  // The sink holds off for a long stretch while the source keeps offering,
  // so the output and input registers fill and the input stalls.
  task automatic test_backpressure();
    repeat (2) begin
      @(posedge clk_i);
      sink_hold_left = HOLD_CYCLES;
      src_eager = 1'b1;
      send_packet(8'h5C, 8'd10, 8'h00, 1'b0, 1'b1, -1, 1'b0);
      src_eager = 1'b0;
      settle();
    end
  endtask

  // Mostly well-formed packets with random content, mixed with noise,
  // truncated packets, timeouts and rewrites of the timeout register.
  task automatic test_random_traffic();
    int         first_item;
    int         pkt;
    int         cut;
    logic [7:0] len;
    logic [7:0] err;
    first_item = items_sent;
    pkt = 0;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      if (pkt % 16 == 0) begin
        src_eager  = ($urandom_range(0, 3) == 0);
        sink_eager = ($urandom_range(0, 3) == 0);
      end
      if (pkt % 10 == 0) write_timeout(16'($urandom_range(4, 40)));
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      if (pkt == 3) len = 8'd255;  // the largest packet, parameters up to index 252
      else if ($urandom_range(0, 19) == 0) len = 8'($urandom_range(0, 1));
      else len = 8'($urandom_range(2, 9));
      err = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      cut = -1;
      if ($urandom_range(0, 7) == 0)
        cut = $urandom_range(0, (len >= svbd_pkg::MIN_LENGTH) ? int'(len) + 3 : 3);
      send_packet(8'($urandom_range(0, 255)), len, err, ($urandom_range(0, 6) == 0), 1'b1,
                  cut, 1'($urandom_range(0, 1)));
      pkt++;
    end
    src_eager  = 1'b0;
    sink_eager = 1'b0;
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_items();
    test_reset_timeout();
    test_length_and_checksum();
    test_timeout_limits();
    test_backpressure();
    test_random_traffic();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d input transactions and checked %0d result transactions.",
             items_sent, reports_checked);
    $display("Packet endings ok/timeout/bad length/checksum/device error: %0d/%0d/%0d/%0d/%0d",
             status_tally[svbd_pkg::ST_OK], status_tally[svbd_pkg::ST_TIMEOUT],
             status_tally[svbd_pkg::ST_BADLEN], status_tally[svbd_pkg::ST_CHECKSUM],
             status_tally[svbd_pkg::ST_DEVERR]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
